### sv/nntb_pkg.sv
// Shared types and constants for the nearest-neighbour tour builder.
`timescale 1ns / 1ps
`default_nettype none
package nntb_pkg;
    localparam int CITY_W  = 8;
    localparam int EDGE_W  = 21;
    localparam int TOTAL_W = 30;
    localparam logic [EDGE_W-1:0]  EDGE_MAX  = {EDGE_W{1'b1}};
    localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};
    typedef logic [1:0] phase_t;
    localparam phase_t PH_LOAD  = 2'd0;
    localparam phase_t PH_READY = 2'd1;
    localparam phase_t PH_TOUR  = 2'd2;
    localparam phase_t PH_DONE  = 2'd3;
endpackage
`default_nettype wire

### sv/nntb_ram.sv
// Generic single-port-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module nntb_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 256
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

### sv/nntb_sqrt.sv
// Bit-serial integer square root giving floor(2*sqrt(s)).
`timescale 1ns / 1ps
`default_nettype none
module nntb_sqrt #(
    parameter int SW = 64
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          start,
    input  wire logic [SW-1:0] s,
    output logic               busy,
    output logic [SW/2:0]      t
);
    localparam int OPW = SW + 2;
    localparam int RW  = SW / 2 + 1;
    localparam int CW  = $clog2(RW + 1);
    logic [OPW-1:0] rem_reg;
    logic [OPW-1:0] op_reg;
    logic [RW-1:0]  root_reg;
    logic [CW-1:0]  cnt_reg;
    logic [OPW+1:0] trial;
    logic [OPW+1:0] rem_sh;

    // root of 4*s, digit by digit
    always_comb begin
        rem_sh = {rem_reg, op_reg[OPW-1 -: 2]};
        trial  = {{(OPW-RW){1'b0}}, root_reg, 2'b01};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else if (start) begin
            cnt_reg <= CW'(RW);
        end else if (cnt_reg != '0) begin
            cnt_reg <= cnt_reg - 1'b1;
        end
        if (start) begin
            op_reg   <= {s, 2'b00};
            rem_reg  <= '0;
            root_reg <= '0;
        end else if (cnt_reg != '0) begin
            op_reg <= {op_reg[OPW-3:0], 2'b00};
            if (rem_sh >= trial) begin
                rem_reg  <= OPW'(rem_sh - trial);
                root_reg <= {root_reg[RW-2:0], 1'b1};
            end else begin
                rem_reg  <= OPW'(rem_sh);
                root_reg <= {root_reg[RW-2:0], 1'b0};
            end
        end
    end
    assign busy = (cnt_reg != '0);
    assign t    = root_reg;
endmodule
`default_nettype wire

### sv/nearest_neighbour_tour_builder_core.sv
// Nearest-neighbour tour builder: top level.
// Input words: mode 0 loads one city (coord_x, coord_y) in order, last_city
// ends the set; mode 1 asks for the next tour city. Result words carry city,
// edge_length, total_distance and tour_end; loads never give a result.
// Coordinates sit in one RAM, open flags in a second, both with registered
// read. A step reads the current city, then scans all loaded cities: a closed
// one is skipped after its flag read; an open one costs a RAM read, a 25x25
// square sum and a bit-serial square root. The closing step adds one more
// distance to city 0. Starting a tour sets the open flags with one write per
// city, leaving only city 0 closed. Loads are taken one per cycle while no
// result word is pending. Reset empties the set (phase LOAD, no cities). A
// stalled receiver holds the result in the output register; no new word is
// taken until it is delivered.
`timescale 1ns / 1ps
`default_nettype none
module nearest_neighbour_tour_builder_core #(
    parameter int MAX_CITIES = 256,
    parameter int COORD_BITS = 24,
    parameter int FRAC_BITS  = 4
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           s_valid,
    output logic                                s_ready,
    input  wire logic                           s_mode,
    input  wire logic signed [COORD_BITS-1:0]   s_coord_x,
    input  wire logic signed [COORD_BITS-1:0]   s_coord_y,
    input  wire logic                           s_last_city,
    output logic                                m_valid,
    input  wire logic                           m_ready,
    output logic [nntb_pkg::CITY_W-1:0]         m_city,
    output logic [nntb_pkg::EDGE_W-1:0]         m_edge_length,
    output logic [nntb_pkg::TOTAL_W-1:0]        m_total_distance,
    output logic                                m_tour_end
);
    import nntb_pkg::*;
    localparam int AW = $clog2(MAX_CITIES);
    localparam int NW = AW + 1;
    localparam int DW = COORD_BITS + 1;
    localparam int SW = 2 * DW + 2;
    localparam int TW = SW / 2 + 1;

    typedef enum logic [3:0] {
        S_IDLE, S_CLEAR, S_CUR, S_CURW, S_RD, S_RDW, S_SQ, S_SQRT, S_SQW, S_DONE
    } st_t;

    st_t            st_reg;
    phase_t         phase_reg;
    logic [NW-1:0]  count_reg;
    logic [AW-1:0]  cur_reg;
    logic [TOTAL_W-1:0] total_reg;
    logic [NW-1:0]  idx_reg;
    logic           closing_reg;
    logic           found_reg;
    logic [AW-1:0]  best_reg;
    logic [EDGE_W-1:0] bestd_reg;
    logic signed [COORD_BITS-1:0] cx_reg, cy_reg;
    logic [SW-1:0]  sq_reg;
    logic [DW-1:0]  dx_reg, dy_reg;

    logic                 c_we, f_we, f_wd, f_rd;
    logic [AW-1:0]        c_wa, c_ra, f_wa, f_ra;
    logic [2*COORD_BITS-1:0] c_wd, c_rd;
    logic                 sq_start, sq_busy;
    logic [TW-1:0]        sq_t;
    logic [TW:0]          e_sum;
    logic [TW-FRAC_BITS-1:0] e_raw;
    logic [EDGE_W-1:0]    e_val;
    logic [TOTAL_W:0]     tot_sum;
    logic signed [COORD_BITS:0] ddx, ddy;

    nntb_ram #(.WIDTH(2*COORD_BITS), .DEPTH(MAX_CITIES)) u_coord (
        .aclk(aclk), .we(c_we), .waddr(c_wa), .wdata(c_wd), .raddr(c_ra), .rdata(c_rd)
    );
    nntb_ram #(.WIDTH(1), .DEPTH(MAX_CITIES)) u_open (
        .aclk(aclk), .we(f_we), .waddr(f_wa), .wdata(f_wd), .raddr(f_ra), .rdata(f_rd)
    );
    nntb_sqrt #(.SW(SW)) u_sqrt (
        .aclk(aclk), .aresetn(aresetn), .start(sq_start), .s(sq_reg),
        .busy(sq_busy), .t(sq_t)
    );

    assign s_ready = (st_reg == S_IDLE) && !m_valid;
    wire take = s_valid && s_ready;
    wire load_new = (phase_reg != PH_LOAD);
    wire [NW-1:0] load_cnt = load_new ? '0 : count_reg;
    wire load_wr = take && !s_mode && (load_cnt < NW'(MAX_CITIES));

    always_comb begin
        c_we = load_wr;
        c_wa = AW'(load_cnt);
        c_wd = {s_coord_x, s_coord_y};
        c_ra = (st_reg == S_CUR) ? cur_reg : AW'(idx_reg);
        f_ra = AW'(idx_reg);
        f_we = 1'b0;
        f_wa = AW'(idx_reg);
        f_wd = 1'b1;
        if (st_reg == S_CLEAR) begin
            f_we = 1'b1;
            f_wd = (idx_reg != '0);
        end else if (st_reg == S_DONE && found_reg && !closing_reg) begin
            f_we = 1'b1;
            f_wa = best_reg;
            f_wd = 1'b0;
        end
        ddx = $signed({cx_reg[COORD_BITS-1], cx_reg})
            - $signed({c_rd[2*COORD_BITS-1], c_rd[2*COORD_BITS-1 -: COORD_BITS]});
        ddy = $signed({cy_reg[COORD_BITS-1], cy_reg})
            - $signed({c_rd[COORD_BITS-1], c_rd[COORD_BITS-1:0]});
        sq_start = (st_reg == S_SQRT);
        e_sum = {1'b0, sq_t} + (TW+1)'(1 << FRAC_BITS);
        e_raw = e_sum[TW:FRAC_BITS+1];
        if ($bits(e_raw) > EDGE_W && (e_raw >> EDGE_W) != '0) begin
            e_val = EDGE_MAX;
        end else begin
            e_val = EDGE_W'(e_raw);
        end
        tot_sum = {1'b0, total_reg} + (TOTAL_W+1)'(bestd_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg    <= S_IDLE;
            phase_reg <= PH_LOAD;
            count_reg <= '0;
            cur_reg   <= '0;
            total_reg <= '0;
            m_valid   <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                m_valid <= 1'b0;
            end
            case (st_reg)
                S_IDLE: begin
                    if (take && !s_mode) begin
                        if (load_wr) begin
                            count_reg <= load_cnt + 1'b1;
                        end else begin
                            count_reg <= load_cnt;
                        end
                        if (s_last_city && (load_wr || load_cnt != '0)) begin
                            phase_reg <= PH_READY;
                        end else begin
                            phase_reg <= PH_LOAD;
                        end
                    end else if (take && phase_reg == PH_READY) begin
                        idx_reg <= '0;
                        st_reg  <= S_CLEAR;
                    end else if (take && phase_reg == PH_TOUR) begin
                        st_reg <= S_CUR;
                    end
                end
                S_CLEAR: begin
                    if (idx_reg == count_reg - 1'b1) begin
                        cur_reg          <= '0;
                        total_reg        <= '0;
                        phase_reg        <= PH_TOUR;
                        m_city           <= '0;
                        m_edge_length    <= '0;
                        m_total_distance <= '0;
                        m_tour_end       <= 1'b0;
                        m_valid          <= 1'b1;
                        st_reg           <= S_IDLE;
                    end
                    idx_reg <= idx_reg + 1'b1;
                end
                S_CUR: begin
                    idx_reg     <= '0;
                    found_reg   <= 1'b0;
                    closing_reg <= 1'b0;
                    st_reg      <= S_CURW;
                end
                S_CURW: begin
                    cx_reg <= c_rd[2*COORD_BITS-1 -: COORD_BITS];
                    cy_reg <= c_rd[COORD_BITS-1:0];
                    st_reg <= S_RD;
                end
                S_RD: begin
                    if (idx_reg == count_reg) begin
                        if (found_reg) begin
                            st_reg <= S_DONE;
                        end else begin
                            closing_reg <= 1'b1;
                            idx_reg     <= '0;
                        end
                    end else begin
                        st_reg <= S_RDW;
                    end
                end
                S_RDW: begin
                    if (f_rd || closing_reg) begin
                        dx_reg <= ddx[COORD_BITS] ? DW'(-ddx) : DW'(ddx);
                        dy_reg <= ddy[COORD_BITS] ? DW'(-ddy) : DW'(ddy);
                        st_reg <= S_SQ;
                    end else begin
                        idx_reg <= idx_reg + 1'b1;
                        st_reg  <= S_RD;
                    end
                end
                S_SQ: begin
                    st_reg <= S_SQRT;
                end
                S_SQRT: begin
                    st_reg <= S_SQW;
                end
                S_SQW: begin
                    if (!sq_busy) begin
                        if (closing_reg) begin
                            best_reg  <= '0;
                            bestd_reg <= e_val;
                            found_reg <= 1'b1;
                            st_reg    <= S_DONE;
                        end else begin
                            if (!found_reg || e_val < bestd_reg) begin
                                best_reg  <= AW'(idx_reg);
                                bestd_reg <= e_val;
                                found_reg <= 1'b1;
                            end
                            idx_reg <= idx_reg + 1'b1;
                            st_reg  <= S_RD;
                        end
                    end
                end
                S_DONE: begin
                    total_reg <= tot_sum[TOTAL_W] ? TOTAL_MAX : tot_sum[TOTAL_W-1:0];
                    m_total_distance <= tot_sum[TOTAL_W] ? TOTAL_MAX
                                                         : tot_sum[TOTAL_W-1:0];
                    cur_reg          <= best_reg;
                    m_city           <= CITY_W'(best_reg);
                    m_edge_length    <= bestd_reg;
                    m_tour_end       <= closing_reg;
                    m_valid          <= 1'b1;
                    if (closing_reg) begin
                        phase_reg <= PH_DONE;
                    end
                    st_reg <= S_IDLE;
                end
                default: st_reg <= S_IDLE;
            endcase
        end
    end

    // square sum registered ahead of the root unit
    always_ff @(posedge aclk) begin
        if (st_reg == S_SQ) begin
            sq_reg <= SW'(dx_reg * dx_reg) + SW'(dy_reg * dy_reg);
        end
    end
endmodule
`default_nettype wire

### sv/nntb_checker.sv
// Port-level checker for the tour builder, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module nntb_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_valid,
    input wire logic        s_ready,
    input wire logic        m_valid,
    input wire logic        m_ready,
    input wire logic [7:0]  m_city,
    input wire logic [20:0] m_edge_length,
    input wire logic [29:0] m_total_distance,
    input wire logic        m_tour_end
);
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_total_distance))
        else $error("result word dropped while stalled");
    a_noacc: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !s_ready)
        else $error("input taken while result pending");
    a_end: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_tour_end |-> m_city == 8'd0)
        else $error("tour end not at city 0");
    a_edge: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_city == 8'd0 && !m_tour_end |-> m_edge_length == 21'd0)
        else $error("first step has nonzero edge");
endmodule

bind nearest_neighbour_tour_builder_core nntb_checker u_nntb_checker (.*);
`default_nettype wire

### tb/sv/nearest_neighbour_tour_builder_core_tb.sv
// Testbench for the nearest-neighbour tour builder: random sets, tours and stalls.
`timescale 1ns / 1ps
module nearest_neighbour_tour_builder_core_tb;
    import nntb_pkg::*;

    localparam int NCITY = 256;
    localparam int CW    = 24;
    localparam logic MODE_LOAD = 1'b0;
    localparam logic MODE_STEP = 1'b1;
    localparam int IDLE_LIMIT = 60000;

    typedef struct {
        logic [CITY_W-1:0]  city;
        logic [EDGE_W-1:0]  edge_len;
        logic [TOTAL_W-1:0] total;
        logic               tour_end;
    } tour_word_t;

    class tour_scoreboard;
        logic signed [CW-1:0] xs[NCITY];
        logic signed [CW-1:0] ys[NCITY];
        bit                   open_c[NCITY];
        int                   n_cities;
        int                   cur;
        logic [TOTAL_W-1:0]   total;
        phase_t               ph;
        tour_word_t           pending_q[$];
        int                   errors;

        function new();
            n_cities = 0;
            cur = 0;
            total = '0;
            ph = PH_LOAD;
            errors = 0;
        endfunction

        function longint unsigned root_floor(longint unsigned s);
            longint unsigned r, c;
            r = 0;
            for (int b = 26; b >= 0; b--) begin
                c = r | (64'd1 << b);
                if (c * c <= s) r = c;
            end
            return r;
        endfunction

        function logic [EDGE_W-1:0] edge_between(int a, int b);
            longint dx, dy;
            longint unsigned s, r, t, e;
            dx = longint'(xs[a]) - longint'(xs[b]);
            dy = longint'(ys[a]) - longint'(ys[b]);
            if (dx < 0) dx = -dx;
            if (dy < 0) dy = -dy;
            s = dx * dx + dy * dy;
            r = root_floor(s);
            t = 2 * r + ((s - r * r > r) ? 1 : 0);
            e = (t + 16) >> 5;
            return (e > EDGE_MAX) ? EDGE_MAX : e[EDGE_W-1:0];
        endfunction

        function void add_edge(logic [EDGE_W-1:0] e);
            longint unsigned t;
            t = longint'(total) + e;
            total = (t > TOTAL_MAX) ? TOTAL_MAX : t[TOTAL_W-1:0];
        endfunction

        function void note_word(logic mode, logic signed [CW-1:0] x,
                                logic signed [CW-1:0] y, logic last);
            tour_word_t w;
            int best;
            logic [EDGE_W-1:0] best_d, d;
            bit found;
            if (mode == MODE_LOAD) begin
                if (ph != PH_LOAD) begin
                    n_cities = 0;
                    ph = PH_LOAD;
                end
                if (n_cities < NCITY) begin
                    xs[n_cities] = x;
                    ys[n_cities] = y;
                    open_c[n_cities] = 1;
                    n_cities++;
                end
                if (last && n_cities > 0) ph = PH_READY;
                return;
            end
            if (ph == PH_READY) begin
                for (int i = 0; i < n_cities; i++) open_c[i] = 1;
                open_c[0] = 0;
                cur = 0;
                total = '0;
                ph = PH_TOUR;
                w = '{city: '0, edge_len: '0, total: '0, tour_end: 1'b0};
                pending_q = {pending_q, w};
                return;
            end
            if (ph != PH_TOUR) return;
            found = 0;
            best = 0;
            best_d = '0;
            for (int i = 0; i < n_cities; i++) begin
                if (open_c[i]) begin
                    d = edge_between(cur, i);
                    if (!found || d < best_d) begin
                        found = 1;
                        best = i;
                        best_d = d;
                    end
                end
            end
            if (found) begin
                open_c[best] = 0;
                cur = best;
                add_edge(best_d);
                w = '{city: best[CITY_W-1:0], edge_len: best_d, total: total,
                      tour_end: 1'b0};
            end else begin
                best_d = edge_between(cur, 0);
                add_edge(best_d);
                cur = 0;
                ph = PH_DONE;
                w = '{city: '0, edge_len: best_d, total: total, tour_end: 1'b1};
            end
            pending_q = {pending_q, w};
        endfunction

        task report(string what, longint got, longint want);
            $display("mismatch %s: got %0d expected %0d", what, got, want);
            errors++;
        endtask

        task check_word(tour_word_t got);
            tour_word_t want;
            if (pending_q.size() == 0) begin
                report("unexpected word, city", got.city, -1);
                return;
            end
            want = pending_q.pop_front();
            if (got.city !== want.city) report("city", got.city, want.city);
            if (got.edge_len !== want.edge_len)
                report("edge_length", got.edge_len, want.edge_len);
            if (got.total !== want.total)
                report("total_distance", got.total, want.total);
            if (got.tour_end !== want.tour_end)
                report("tour_end", got.tour_end, want.tour_end);
        endtask
    endclass

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic s_mode = 1'b0;
    logic signed [CW-1:0] s_coord_x = '0;
    logic signed [CW-1:0] s_coord_y = '0;
    logic s_last_city = 1'b0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic [CITY_W-1:0]  m_city;
    logic [EDGE_W-1:0]  m_edge_length;
    logic [TOTAL_W-1:0] m_total_distance;
    logic m_tour_end;

    tour_scoreboard sb = new();
    bit quiet = 0;
    bit hold_req = 0;
    bit held = 0;
    int words_sent = 0;
    int idle_cycles = 0;

    always #4 aclk = ~aclk;

    nearest_neighbour_tour_builder_core dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_mode(s_mode),
        .s_coord_x(s_coord_x), .s_coord_y(s_coord_y), .s_last_city(s_last_city),
        .m_valid(m_valid), .m_ready(m_ready), .m_city(m_city),
        .m_edge_length(m_edge_length), .m_total_distance(m_total_distance),
        .m_tour_end(m_tour_end)
    );

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            sb.check_word('{city: m_city, edge_len: m_edge_length,
                            total: m_total_distance, tour_end: m_tour_end});
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("FAIL nearest_neighbour_tour_builder_core");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        @(posedge aclk iff aresetn);
        forever begin
            if (hold_req && !held) begin
                held = 1;
                m_ready <= 1'b0;
                repeat (3000) @(posedge aclk);
            end else if (!quiet && $urandom_range(0, 3) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 19)) @(posedge aclk);
            end else begin
                m_ready <= 1'b1;
                repeat ($urandom_range(1, 30)) @(posedge aclk);
            end
        end
    end

    task automatic send_word(logic mode, logic signed [CW-1:0] x,
                             logic signed [CW-1:0] y, logic last);
        if (!quiet && $urandom_range(0, 4) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_mode <= mode;
        s_coord_x <= x;
        s_coord_y <= y;
        s_last_city <= last;
        do @(posedge aclk); while (!s_ready);
        sb.note_word(mode, x, y, last);
        words_sent++;
    endtask

    task automatic load_city(int x, int y, logic last);
        send_word(MODE_LOAD, x[CW-1:0], y[CW-1:0], last);
    endtask

    task automatic step_tour(int n);
        repeat (n) send_word(MODE_STEP, CW'($urandom), CW'($urandom),
                             1'($urandom_range(0, 1)));
    endtask

    task automatic load_random_set(int n, bit narrow);
        int x, y;
        for (int i = 0; i < n; i++) begin
            x = narrow ? $urandom_range(0, 8) * 16 - 64 : $urandom;
            y = narrow ? $urandom_range(0, 8) * 16 - 64 : $urandom;
            load_city(x, y, i == n - 1);
        end
    endtask

    initial begin
        int n;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        step_tour(2);
        load_city(100, -100, 1'b1);
        step_tour(3);
        load_city(-8388608, -8388608, 1'b0);
        load_city(8388607, 8388607, 1'b0);
        load_city(0, 0, 1'b0);
        step_tour(1);
        load_city(-8388608, 8388607, 1'b1);
        step_tour(6);
        load_city(0, 0, 1'b0);
        load_city(16, 0, 1'b0);
        load_city(-16, 0, 1'b0);
        load_city(0, 16, 1'b1);
        step_tour(3);
        load_city(8, 8, 1'b0);
        load_city(8, 8, 1'b1);
        step_tour(4);

        while (words_sent < 575) begin
            if (words_sent > 300 && !hold_req) hold_req = 1;
            if (words_sent > 450) quiet = 1;
            n = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 2) : $urandom_range(3, 9);
            case ($urandom_range(0, 9))
                0: begin
                    load_random_set(n, 1'b0);
                    step_tour($urandom_range(1, n));
                end
                1: begin
                    for (int i = 0; i < n; i++) load_city($urandom, $urandom, 1'b0);
                    step_tour(2);
                    load_city($urandom, $urandom, 1'b1);
                    step_tour(n + 2);
                end
                2: begin
                    load_random_set(n, 1'b1);
                    step_tour(n + 1 + $urandom_range(1, 3));
                end
                default: begin
                    load_random_set(n, 1'($urandom_range(0, 1)));
                    step_tour(n + 1);
                end
            endcase
        end

        for (int i = 0; i < NCITY + 3; i++)
            load_city($urandom, $urandom, i == NCITY + 2);
        step_tour(3);
        quiet = 1;
        load_random_set(4, 1'b0);
        step_tour(6);

        s_valid <= 1'b0;
        while (sb.pending_q.size() != 0) @(posedge aclk);
        repeat (300) @(posedge aclk);
        if (sb.errors == 0) begin
            $display("PASS nearest_neighbour_tour_builder_core");
        end else begin
            $display("FAIL nearest_neighbour_tour_builder_core");
        end
        $finish;
    end
endmodule

### filelist.f
sv/nntb_pkg.sv
sv/nntb_ram.sv
sv/nntb_sqrt.sv
sv/nearest_neighbour_tour_builder_core.sv
sv/nntb_checker.sv
tb/sv/nearest_neighbour_tour_builder_core_tb.sv
